[hw/rtl/yhw_pkg.sv]
`default_nettype none
package yhw_pkg;

  localparam int OP_W       = 2;
  localparam int PLANE_W    = 2;
  localparam int INDEX_W    = 12;
  localparam int POS_W      = 28;
  localparam int SAMPLE_W   = 8;
  localparam int SRC_W_W    = 13;
  // table address before the wrap, room for 2j+1 of the largest column
  localparam int TADDR_W    = INDEX_W + 1;

  // result queue depth and its fill count width
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_TABLE_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE_LOAD = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

  localparam logic [PLANE_W-1:0] PLANE_Y    = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U    = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V    = 2'd2;
  localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [PLANE_W-1:0]  plane;
    logic [INDEX_W-1:0]  index;
    logic [POS_W-1:0]    position;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0]  out_plane;
    logic [INDEX_W-1:0]  out_column;
    logic [SAMPLE_W-1:0] out_value;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TABLE_WR,
    CMD_LINE_WR,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [PLANE_W-1:0]  plane;
    logic [INDEX_W-1:0]  index;
    logic [TADDR_W-1:0]  taddr;
    logic [POS_W-1:0]    position;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/yhw_fifo.sv]
`default_nettype none
module yhw_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  T                                  wdata,
  input  wire logic                         pop,
  output T                                  rdata,
  output logic                              empty,
  output logic                              full,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  // depth is a power of two so the pointers wrap on their own
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/yhw_front.sv]
`default_nettype none
module yhw_front #(
  parameter int MAX_SOURCE_WIDTH = 4096,
  parameter int MAX_TARGET_WIDTH = 4096
) (
  input  yhw_pkg::in_item_t item,
  output yhw_pkg::cmd_t     cmd,
  output logic              keep
);
  import yhw_pkg::*;

  localparam int CHROMA_DEPTH = MAX_SOURCE_WIDTH / 2;

  // drop items with no effect, turn the rest into back-end commands
  always_comb begin
    cmd.kind     = CMD_COMPUTE;
    cmd.plane    = item.plane;
    cmd.index    = item.index;
    cmd.position = item.position;
    cmd.sample   = item.sample;
    cmd.taddr    = {1'b0, item.index};
    keep         = 1'b0;
    case (item.operation)
      OP_TABLE_LOAD: begin
        cmd.kind = CMD_TABLE_WR;
        keep     = int'(item.index) < MAX_TARGET_WIDTH;
      end
      OP_SAMPLE_LOAD: begin
        cmd.kind = CMD_LINE_WR;
        case (item.plane)
          PLANE_Y:          keep = int'(item.index) < MAX_SOURCE_WIDTH;
          PLANE_U, PLANE_V: keep = int'(item.index) < CHROMA_DEPTH;
          default:          keep = 1'b0;
        endcase
      end
      OP_COMPUTE: begin
        cmd.kind = CMD_COMPUTE;
        keep     = (item.plane != PLANE_NONE);
        // chroma column j reads entry 2j+1
        if (item.plane != PLANE_Y) begin
          cmd.taddr = {item.index, 1'b1};
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/yhw_back.sv]
`default_nettype none
module yhw_back #(
  parameter int MAX_SOURCE_WIDTH = 4096,
  parameter int MAX_TARGET_WIDTH = 4096,
  parameter int FRAC_BITS        = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [yhw_pkg::SRC_W_W-1:0]  source_width,
  input  yhw_pkg::cmd_t                     cmd,
  input  wire logic                         cmd_valid,
  output logic                              cmd_pop,
  input  wire logic [yhw_pkg::OUT_CW-1:0]   out_count,
  output logic                              res_push,
  output yhw_pkg::out_item_t                res
);
  import yhw_pkg::*;

  localparam int LAW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int CAW    = LAW - 1;
  localparam int TAW    = $clog2(MAX_TARGET_WIDTH);
  localparam int CDEPTH = MAX_SOURCE_WIDTH / 2;
  localparam int IW     = POS_W - FRAC_BITS;
  localparam int VW0    = (IW + 1 > SRC_W_W) ? IW + 1 : SRC_W_W;
  localparam int VW     = (VW0 > LAW + 1) ? VW0 : LAW + 1;
  localparam int AW     = SAMPLE_W + FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // issue
  logic                 room_ok;
  logic [OUT_CW:0]      pending;
  logic [TAW-1:0]       taddr;
  logic [POS_W-1:0]     table_mem [MAX_TARGET_WIDTH];
  logic [POS_W-1:0]     tab_q;

  // stage 1
  logic                 p1_valid;
  cmd_kind_t            p1_kind;
  logic [PLANE_W-1:0]   p1_plane;
  logic [INDEX_W-1:0]   p1_index;
  logic [SAMPLE_W-1:0]  p1_sample;
  logic [FRAC_BITS-1:0] frac;
  logic [VW-1:0]        a0;
  logic [VW-1:0]        a1;
  logic [VW-1:0]        limit;
  logic [VW-1:0]        a0_sat;
  logic [VW-1:0]        a1_sat;
  logic [LAW-1:0]       addr0;
  logic [LAW-1:0]       addr1;

  // stage 2
  logic                 p2_valid;
  cmd_kind_t            p2_kind;
  logic [PLANE_W-1:0]   p2_plane;
  logic [INDEX_W-1:0]   p2_index;
  logic [SAMPLE_W-1:0]  p2_sample;
  logic [FRAC_BITS-1:0] p2_frac;
  logic [LAW-1:0]       p2_addr0;
  logic [LAW-1:0]       p2_addr1;
  logic [SAMPLE_W-1:0]  luma_line [MAX_SOURCE_WIDTH];
  logic [SAMPLE_W-1:0]  u_line [CDEPTH];
  logic [SAMPLE_W-1:0]  v_line [CDEPTH];

  // stage 3
  logic                 p3_valid;
  logic [PLANE_W-1:0]   p3_plane;
  logic [INDEX_W-1:0]   p3_index;
  logic [FRAC_BITS-1:0] p3_frac;
  logic [SAMPLE_W-1:0]  y0_q, y1_q, u0_q, u1_q, v0_q, v1_q;
  logic [SAMPLE_W-1:0]  s0;
  logic [SAMPLE_W-1:0]  s1;
  logic [FRAC_BITS:0]   wfrac;
  logic [AW-1:0]        acc;

  // a compute issues only when the result queue has room for it and all
  // computes still in flight
  assign pending = (OUT_CW+1)'(out_count)
                 + (OUT_CW+1)'(p1_valid && p1_kind == CMD_COMPUTE)
                 + (OUT_CW+1)'(p2_valid && p2_kind == CMD_COMPUTE)
                 + (OUT_CW+1)'(p3_valid);
  assign room_ok = pending < (OUT_CW+1)'(OUT_DEPTH);
  assign cmd_pop = cmd_valid && (cmd.kind != CMD_COMPUTE || room_ok);
  assign taddr   = TAW'(cmd.taddr);

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_TABLE_WR) begin
      table_mem[taddr] <= cmd.position;
    end
    tab_q <= table_mem[taddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      p1_valid <= cmd_pop && cmd.kind != CMD_TABLE_WR;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid && p2_kind == CMD_COMPUTE;
    end
  end

  always_ff @(posedge clk) begin
    p1_kind   <= cmd.kind;
    p1_plane  <= cmd.plane;
    p1_index  <= cmd.index;
    p1_sample <= cmd.sample;
  end

  // source indices: lower from the integer part, upper one further when
  // there is a fraction, limited to the row, halved for chroma, saturated
  always_comb begin
    frac  = tab_q[FRAC_BITS-1:0];
    a0    = VW'(tab_q[POS_W-1:FRAC_BITS]);
    a1    = a0 + VW'(frac != '0);
    limit = (source_width == '0) ? '0 : VW'(source_width - SRC_W_W'(1));
    if (a1 > limit) begin
      a1 = limit;
    end
    if (p1_plane == PLANE_Y) begin
      a0_sat = (a0 >= VW'(MAX_SOURCE_WIDTH)) ? VW'(MAX_SOURCE_WIDTH - 1) : a0;
      a1_sat = (a1 >= VW'(MAX_SOURCE_WIDTH)) ? VW'(MAX_SOURCE_WIDTH - 1) : a1;
    end else begin
      a0_sat = ((a0 >> 1) >= VW'(CDEPTH)) ? VW'(CDEPTH - 1) : (a0 >> 1);
      a1_sat = ((a1 >> 1) >= VW'(CDEPTH)) ? VW'(CDEPTH - 1) : (a1 >> 1);
    end
    if (p1_kind == CMD_LINE_WR) begin
      addr0 = LAW'(p1_index);
      addr1 = LAW'(p1_index);
    end else begin
      addr0 = LAW'(a0_sat);
      addr1 = LAW'(a1_sat);
    end
  end

  always_ff @(posedge clk) begin
    p2_kind   <= p1_kind;
    p2_plane  <= p1_plane;
    p2_index  <= p1_index;
    p2_sample <= p1_sample;
    p2_frac   <= frac;
    p2_addr0  <= addr0;
    p2_addr1  <= addr1;
  end

  // line stores, one write port and two read ports each
  always_ff @(posedge clk) begin
    if (p2_valid && p2_kind == CMD_LINE_WR) begin
      case (p2_plane)
        PLANE_Y: luma_line[p2_addr0] <= p2_sample;
        PLANE_U: u_line[p2_addr0[CAW-1:0]] <= p2_sample;
        PLANE_V: v_line[p2_addr0[CAW-1:0]] <= p2_sample;
        default: ;
      endcase
    end
    y0_q <= luma_line[p2_addr0];
    y1_q <= luma_line[p2_addr1];
    u0_q <= u_line[p2_addr0[CAW-1:0]];
    u1_q <= u_line[p2_addr1[CAW-1:0]];
    v0_q <= v_line[p2_addr0[CAW-1:0]];
    v1_q <= v_line[p2_addr1[CAW-1:0]];
  end

  always_ff @(posedge clk) begin
    p3_plane <= p2_plane;
    p3_index <= p2_index;
    p3_frac  <= p2_frac;
  end

  // linear blend, truncated
  always_comb begin
    case (p3_plane)
      PLANE_U: begin
        s0 = u0_q;
        s1 = u1_q;
      end
      PLANE_V: begin
        s0 = v0_q;
        s1 = v1_q;
      end
      default: begin
        s0 = y0_q;
        s1 = y1_q;
      end
    endcase
    wfrac = ONE - (FRAC_BITS+1)'(p3_frac);
    acc   = AW'(s0) * AW'(wfrac) + AW'(s1) * AW'(p3_frac);
  end

  assign res_push       = p3_valid;
  assign res.out_plane  = p3_plane;
  assign res.out_column = p3_index;
  assign res.out_value  = acc[FRAC_BITS +: SAMPLE_W];

endmodule
`default_nettype wire

[hw/rtl/yuv420_table_driven_horizontal_warp_unit.sv]
`default_nettype none
// horizontal warp of planar yuv420 rows through a position table. each input
// item is one of three operations: load a table entry (unsigned fixed point
// source position, FRAC_BITS fraction bits), load one source sample into the
// luma, u or v line store, or compute one target sample. a compute of luma
// column x uses table entry x; chroma column j uses entry 2j+1 with both source
// indices halved. the upper index is limited to source_width-1 and the two
// samples are blended and truncated to 8 bits. only computes give a result
// item, carrying plane, column and value; loads and items with unused codes
// or out-of-range load addresses give none. table and line stores are not
// cleared at reset: a compute that reads an entry never loaded returns an
// arbitrary value. MAX_SOURCE_WIDTH and MAX_TARGET_WIDTH must be powers of
// two; table addresses wrap modulo MAX_TARGET_WIDTH. the user must write
// source_width through cfg_we/cfg_wdata only while the block is idle; the
// block does not enforce it. rate: one item per clock is taken on the input
// side and one result per clock delivered while pop keeps up; a compute passes
// the command queue, table read, index math and line store read with the
// blend into the result queue; the table and line store reads are registered.
// the input side sees full only when the four-entry command queue backs up
// behind a result queue of eight that is not drained fast enough.
module yuv420_table_driven_horizontal_warp_unit #(
  parameter int MAX_SOURCE_WIDTH = 4096,
  parameter int MAX_TARGET_WIDTH = 4096,
  parameter int FRAC_BITS        = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [yhw_pkg::SRC_W_W-1:0] cfg_wdata,
  input  wire logic                        push,
  input  yhw_pkg::in_item_t                item,
  output logic                             full,
  input  wire logic                        pop,
  output yhw_pkg::out_item_t               result,
  output logic                             empty
);
  import yhw_pkg::*;

  localparam int CMD_DEPTH = 4;

  logic [SRC_W_W-1:0] source_width;
  cmd_t               front_cmd;
  logic               front_keep;
  cmd_t               q_cmd;
  logic               q_empty;
  logic               q_pop;
  logic               res_push;
  out_item_t          res;
  logic [OUT_CW-1:0]  out_count;

  // configuration register, reset to the widest row
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= SRC_W_W'(4096);
    end else if (cfg_we) begin
      source_width <= cfg_wdata;
    end
  end

  // front end: decode the item, drop those with no effect
  yhw_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH)
  ) u_front (
    .item (item),
    .cmd  (front_cmd),
    .keep (front_keep)
  );

  // command queue between front and back end
  yhw_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && front_keep),
    .wdata (front_cmd),
    .pop   (q_pop),
    .rdata (q_cmd),
    .empty (q_empty),
    .full  (full),
    .count ()
  );

  // back end: table, index math, line stores, blend
  yhw_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH),
    .FRAC_BITS        (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .source_width (source_width),
    .cmd          (q_cmd),
    .cmd_valid    (!q_empty),
    .cmd_pop      (q_pop),
    .out_count    (out_count),
    .res_push     (res_push),
    .res          (res)
  );

  // result queue; the back end never pushes without room
  yhw_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .full  (),
    .count (out_count)
  );

endmodule
`default_nettype wire

[sim/yuv420_table_driven_horizontal_warp_unit_test.sv]
`timescale 1ns / 100ps

module yuv420_table_driven_horizontal_warp_unit_test;
  import yhw_pkg::*;

  // block sizes at their defaults
  localparam int SRC_DEPTH    = 4096;
  localparam int TABLE_DEPTH  = 4096;
  localparam int CHROMA_DEPTH = SRC_DEPTH / 2;
  localparam int FRAC         = 16;
  localparam int SAW          = $clog2(SRC_DEPTH);
  localparam int CAW          = SAW - 1;

  // the one operation code the package leaves unnamed
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASE_ITEMS = 190;  // counted items per random phase
  localparam int TRAIL       = 12;   // cycles for loads still in the pipe
  localparam int LONG_HOLD   = 100;  // receiver hold-off, in cycles

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [SRC_W_W-1:0]   cfg_wdata = '0;
  logic                 push      = 1'b0;
  in_item_t             item      = '0;
  logic                 full;
  logic                 pop       = 1'b0;
  out_item_t            result;
  logic                 empty;

  yuv420_table_driven_horizontal_warp_unit #(
    .MAX_SOURCE_WIDTH(SRC_DEPTH),
    .MAX_TARGET_WIDTH(TABLE_DEPTH),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .item(item),
    .full(full),
    .pop(pop),
    .result(result),
    .empty(empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // warp predictor: its own table, line stores and source width, updated from
  // what the block actually takes in
  // ---------------------------------------------------------------------------
  bit [POS_W-1:0]    warp_table [TABLE_DEPTH];
  bit [SAMPLE_W-1:0] luma_store [SRC_DEPTH];
  bit [SAMPLE_W-1:0] u_store    [CHROMA_DEPTH];
  bit [SAMPLE_W-1:0] v_store    [CHROMA_DEPTH];
  logic [SRC_W_W-1:0] warp_width = 13'd4096;

  out_item_t expected_samples [$];  // warped samples still to come out
  in_item_t  items_to_send [$];     // items not yet taken by the block

  int fail_count     = 0;
  int samples_seen   = 0;
  int loads_taken    = 0;
  int ignored_taken  = 0;

  // source taps of one table position: lower and upper line store index,
  // with the upper one limited by the width, halved for chroma and both
  // saturated to the end of their store
  function automatic void source_taps(input logic [POS_W-1:0] pos,
                                      input logic [PLANE_W-1:0] plane,
                                      input logic [SRC_W_W-1:0] width,
                                      output int unsigned lo,
                                      output int unsigned hi);
    int unsigned limit;
    int unsigned depth;
    lo = 32'(pos[POS_W-1:FRAC]);
    hi = lo + ((pos[FRAC-1:0] != 0) ? 1 : 0);
    limit = (width == 0) ? 0 : 32'(width) - 1;
    if (hi > limit) hi = limit;
    depth = SRC_DEPTH;
    if (plane != PLANE_Y) begin
      lo = lo >> 1;
      hi = hi >> 1;
      depth = CHROMA_DEPTH;
    end
    if (lo > depth - 1) lo = depth - 1;
    if (hi > depth - 1) hi = depth - 1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] line_sample(input logic [PLANE_W-1:0] plane,
                                                      input int unsigned idx);
    if (plane == PLANE_Y) return luma_store[SAW'(idx)];
    if (plane == PLANE_U) return u_store[CAW'(idx)];
    return v_store[CAW'(idx)];
  endfunction

  // expected result of one compute
  function automatic out_item_t warp_sample(input logic [PLANE_W-1:0] plane,
                                            input logic [INDEX_W-1:0] column);
    logic [INDEX_W-1:0] taddr;
    logic [POS_W-1:0]   pos;
    int unsigned        lo, hi;
    longint unsigned    frac, acc;
    out_item_t          r;
    // chroma column j reads entry 2j+1, which wraps past the table end
    taddr = (plane == PLANE_Y) ? column : {column[INDEX_W-2:0], 1'b1};
    pos = warp_table[taddr];
    frac = 64'(pos[FRAC-1:0]);
    source_taps(pos, plane, warp_width, lo, hi);
    acc = 64'(line_sample(plane, lo)) * ((64'd1 << FRAC) - frac)
        + 64'(line_sample(plane, hi)) * frac;
    r.out_plane  = plane;
    r.out_column = column;
    r.out_value  = acc[FRAC+SAMPLE_W-1:FRAC];
    return r;
  endfunction

  // one item as the block takes it in
  function automatic void take_item(input in_item_t it);
    case (it.operation)
      OP_TABLE_LOAD: begin
        warp_table[it.index] = it.position;
        loads_taken++;
      end
      OP_SAMPLE_LOAD: begin
        // chroma loads past the half-width store and plane 3 loads are dropped
        if (it.plane == PLANE_Y) begin
          luma_store[it.index] = it.sample;
          loads_taken++;
        end else if (it.plane != PLANE_NONE && it.index < CHROMA_DEPTH) begin
          if (it.plane == PLANE_U) u_store[it.index[CAW-1:0]] = it.sample;
          else v_store[it.index[CAW-1:0]] = it.sample;
          loads_taken++;
        end else begin
          ignored_taken++;
        end
      end
      OP_COMPUTE: begin
        if (it.plane != PLANE_NONE) expected_samples.push_back(warp_sample(it.plane, it.index));
        else ignored_taken++;
      end
      default: ignored_taken++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  int  send_idle_pct = 27;
  int  recv_idle_pct = 64;
  bit  took = 1'b0;  // the offered item went in at the last rising edge

  // acceptance and register writes, seen at the rising edge
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst && cfg_we) warp_width = cfg_wdata;
    if (!rst && push && !full) begin
      take_item(item);
      void'(items_to_send.pop_front());
      took = 1'b1;
    end
  end

  // driver: keeps an item on offer until it is taken, else maybe idles
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !took) begin
      push <= 1'b1;  // still waiting on full
    end else if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      push <= 1'b1;
      item <= items_to_send[0];
    end else begin
      push <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  bit long_hold_armed = 1'b0;
  int hold_count = 0;
  out_item_t want;
  bit bad;

  // pop driver; once armed it holds off for a long stretch so both queues fill
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (long_hold_armed && hold_count < LONG_HOLD) begin
      pop <= 1'b0;
      hold_count++;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each popped item with the oldest expected sample
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got plane %0d column %0d value %0d",
                 $time, result.out_plane, result.out_column, result.out_value);
      end else begin
        want = expected_samples.pop_front();
        samples_seen++;
        bad = 1'b0;
        if (result.out_plane !== want.out_plane) bad = 1'b1;
        if (result.out_column !== want.out_column) bad = 1'b1;
        if (result.out_value !== want.out_value) bad = 1'b1;
        if (bad) begin
          fail_count++;
          $display("%0t: mismatch, expected plane %0d column %0d value %0d, got %0d %0d %0d",
                   $time, want.out_plane, want.out_column, want.out_value,
                   result.out_plane, result.out_column, result.out_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus planning: tracks which entries the queued items will have written
  // so that no compute ever reads an entry that was never loaded
  // ---------------------------------------------------------------------------
  bit [POS_W-1:0]     plan_table [TABLE_DEPTH];
  bit                 plan_table_set [TABLE_DEPTH];
  bit                 plan_luma_set [SRC_DEPTH];
  bit                 plan_u_set [CHROMA_DEPTH];
  bit                 plan_v_set [CHROMA_DEPTH];
  logic [SRC_W_W-1:0] plan_width = 13'd4096;
  int                 useful_items = 0;  // items the block does not just drop

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [PLANE_W-1:0] plane,
                            input logic [INDEX_W-1:0] index, input logic [POS_W-1:0] pos,
                            input logic [SAMPLE_W-1:0] sample);
    in_item_t it;
    it.operation = op;
    it.plane     = plane;
    it.index     = index;
    it.position  = pos;
    it.sample    = sample;
    items_to_send.push_back(it);
    if (op == OP_TABLE_LOAD) begin
      plan_table[index] = pos;
      plan_table_set[index] = 1'b1;
      useful_items++;
    end else if (op == OP_SAMPLE_LOAD) begin
      if (plane == PLANE_Y) begin
        plan_luma_set[index] = 1'b1;
        useful_items++;
      end else if (plane != PLANE_NONE && index < CHROMA_DEPTH) begin
        if (plane == PLANE_U) plan_u_set[index[CAW-1:0]] = 1'b1;
        else plan_v_set[index[CAW-1:0]] = 1'b1;
        useful_items++;
      end
    end else if (op == OP_COMPUTE && plane != PLANE_NONE) begin
      useful_items++;
    end
  endtask

  function automatic logic [POS_W-1:0] random_position();
    int unsigned        pick;
    logic [INDEX_W-1:0] whole;
    logic [FRAC-1:0]    frac;
    pick = $urandom_range(0, 99);
    if (pick < 35) return POS_W'($urandom);
    // the last source column pushes the upper tap past the store end
    if (pick < 40) whole = 12'd4095;
    else if (pick < 80) whole = 12'($urandom_range(0, 31));
    else whole = 12'($urandom);
    frac = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    return {whole, frac};
  endfunction

  // mostly a small window so loaded entries get read again
  function automatic logic [INDEX_W-1:0] pick_column(input int unsigned top);
    if ($urandom_range(0, 1) == 0) return 12'($urandom_range(0, 31));
    return 12'($urandom_range(0, top));
  endfunction

  task automatic fill_line(input logic [PLANE_W-1:0] plane, input int unsigned idx);
    bit done;
    if (plane == PLANE_Y) done = plan_luma_set[SAW'(idx)];
    else if (plane == PLANE_U) done = plan_u_set[CAW'(idx)];
    else done = plan_v_set[CAW'(idx)];
    if (!done)
      queue_item(OP_SAMPLE_LOAD, plane, 12'(idx), POS_W'($urandom), 8'($urandom));
  endtask

  // a compute preceded by whatever loads it still needs
  task automatic queue_compute(input logic [PLANE_W-1:0] plane,
                               input logic [INDEX_W-1:0] column);
    logic [INDEX_W-1:0] taddr;
    int unsigned        lo, hi;
    taddr = (plane == PLANE_Y) ? column : {column[INDEX_W-2:0], 1'b1};
    if (!plan_table_set[taddr])
      queue_item(OP_TABLE_LOAD, 2'($urandom), taddr, random_position(), 8'($urandom));
    source_taps(plan_table[taddr], plane, plan_width, lo, hi);
    fill_line(plane, lo);
    fill_line(plane, hi);
    queue_item(OP_COMPUTE, plane, column, POS_W'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(input int target);
    int                  start;
    int unsigned         pick;
    logic [PLANE_W-1:0]  plane;
    logic [INDEX_W-1:0]  idx;
    start = useful_items;
    while (useful_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        plane = ($urandom_range(0, 1) == 0) ? PLANE_Y : 2'($urandom_range(1, 2));
        queue_compute(plane, pick_column(4095));
      end else if (pick < 65) begin
        queue_item(OP_TABLE_LOAD, 2'($urandom), pick_column(4095), random_position(),
                   8'($urandom));
      end else if (pick < 90) begin
        plane = 2'($urandom_range(0, 2));
        if (plane == PLANE_Y) idx = pick_column(4095);
        else if ($urandom_range(0, 9) == 0) idx = 12'($urandom_range(2048, 4095));
        else idx = pick_column(CHROMA_DEPTH - 1);
        queue_item(OP_SAMPLE_LOAD, plane, idx, POS_W'($urandom), 8'($urandom));
      end else begin
        // noise the block must drop: unused op, plane 3 load or compute
        case ($urandom_range(0, 2))
          0: queue_item(OP_UNUSED, 2'($urandom), 12'($urandom), POS_W'($urandom),
                        8'($urandom));
          1: queue_item(OP_SAMPLE_LOAD, PLANE_NONE, 12'($urandom), POS_W'($urandom),
                        8'($urandom));
          default: queue_item(OP_COMPUTE, PLANE_NONE, 12'($urandom), POS_W'($urandom),
                              8'($urandom));
        endcase
      end
    end
  endtask

  // wait until every item is in and every expected sample is out
  task automatic drain();
    while (items_to_send.size() != 0 || expected_samples.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic program_width(input logic [SRC_W_W-1:0] w);
    drain();
    repeat (TRAIL) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    plan_width = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // short directed opening at the reset width
  task automatic directed_items();
    // table: integer zero, the largest position, half way between 3 and 4
    queue_item(OP_TABLE_LOAD, PLANE_Y, 12'd0, 28'd0, 8'd0);
    queue_item(OP_TABLE_LOAD, PLANE_NONE, 12'd4095, 28'hFFFFFFF, 8'hFF);
    queue_item(OP_TABLE_LOAD, PLANE_U, 12'd1, {12'd3, 16'h8000}, 8'd0);
    // line stores at both ends and the taps the computes below need
    queue_item(OP_SAMPLE_LOAD, PLANE_Y, 12'd0, 28'd0, 8'hFF);
    queue_item(OP_SAMPLE_LOAD, PLANE_Y, 12'd3, 28'd0, 8'd0);
    queue_item(OP_SAMPLE_LOAD, PLANE_Y, 12'd4, 28'd0, 8'd200);
    queue_item(OP_SAMPLE_LOAD, PLANE_Y, 12'd4095, 28'hFFFFFFF, 8'd128);
    queue_item(OP_SAMPLE_LOAD, PLANE_U, 12'd1, 28'd0, 8'd10);
    queue_item(OP_SAMPLE_LOAD, PLANE_U, 12'd2, 28'd0, 8'd250);
    queue_item(OP_SAMPLE_LOAD, PLANE_U, 12'd2047, 28'd0, 8'd33);
    queue_item(OP_SAMPLE_LOAD, PLANE_V, 12'd1, 28'd0, 8'd0);
    queue_item(OP_SAMPLE_LOAD, PLANE_V, 12'd2, 28'd0, 8'hFF);
    queue_item(OP_SAMPLE_LOAD, PLANE_V, 12'd2047, 28'd0, 8'd77);
    // dropped: chroma past its store, plane 3 load, unused op
    queue_item(OP_SAMPLE_LOAD, PLANE_U, 12'd2048, 28'd0, 8'd99);
    queue_item(OP_SAMPLE_LOAD, PLANE_NONE, 12'd5, 28'd0, 8'd99);
    queue_item(OP_UNUSED, PLANE_Y, 12'd0, 28'hFFFFFFF, 8'hFF);
    queue_compute(PLANE_Y, 12'd0);     // zero fraction, both taps equal
    queue_compute(PLANE_Y, 12'd4095);  // upper tap limited by the width
    queue_compute(PLANE_Y, 12'd1);     // plain blend
    queue_compute(PLANE_U, 12'd0);     // chroma reads entry 1, halved taps
    queue_compute(PLANE_V, 12'd0);
    queue_compute(PLANE_V, 12'd2047);  // last chroma column, entry 4095
    queue_compute(PLANE_U, 12'd4095);  // 2j+1 wraps to entry 4095
    queue_item(OP_COMPUTE, PLANE_NONE, 12'd7, 28'd0, 8'd0);  // no result
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SRC_W_W-1:0] w;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_width(13'd4096);
    directed_items();

    for (int ph = 0; ph < 6; ph++) begin
      // idling: sender light / receiver heavy, then swapped, then none
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 64;
      end else if (ph < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // widths: smallest legal, largest legal, zero, field max, one, random
      case (ph)
        0: w = 13'd2;
        1: w = 13'd4096;
        2: w = 13'd0;
        3: w = 13'd8191;
        4: w = 13'd1;
        default: w = 13'($urandom_range(2, 4096));
      endcase
      program_width(w);
      if (ph == 1) long_hold_armed = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (TRAIL) @(posedge clk);

    $display("run: %0d loads and %0d dropped items taken, %0d warped samples checked",
             loads_taken, ignored_taken, samples_seen);
    $display("run: seven source width settings from zero to 8191, three idling mixes, one long stall");
    if (fail_count == 0) begin
      $display("yuv420_table_driven_horizontal_warp_unit verification clean");
    end else begin
      $display("yuv420_table_driven_horizontal_warp_unit verification failed");
    end
    $finish;
  end

  // hard limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("yuv420_table_driven_horizontal_warp_unit verification failed");
    $finish;
  end

endmodule
